/* src/hkrt_pkg.sv */
package hkrt_pkg;

	localparam int SLOT_COUNT_DEF = 6;
	localparam int SHOWN_SLOTS = 6;

	localparam logic [1:0] OP_PRESS = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_RELEASE_ALL = 2'd2;
	localparam logic [1:0] OP_TYPE = 2'd3;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_UNMAPPED = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	localparam logic [7:0] RAW_BASE = 8'd136;
	localparam logic [7:0] SHIFT_FLAG = 8'h80;
	localparam logic [7:0] LEFT_SHIFT_BIT = 8'h02;

	typedef struct packed {
		logic wr;
		logic clr;
	} slot_ctl_t;

	// ascii to usage, bit 7 marks left shift
	localparam logic [7:0] USAGE_ROM [128] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
		8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
		8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
		8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
		8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
		8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
		8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
		8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
		8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
		8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
		8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
		8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
	};

endpackage

/* src/hkrt_slot_file.sv */
module hkrt_slot_file #(
	parameter int SLOT_COUNT = hkrt_pkg::SLOT_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  hkrt_pkg::slot_ctl_t ctl,
	input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] wr_idx,
	input  logic [7:0] wr_data,
	input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] rd_idx,
	output logic [7:0] rd_data,
	output logic [hkrt_pkg::SHOWN_SLOTS-1:0][7:0] shown
);

	logic [7:0] slot_q [SLOT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_q[i] <= 8'd0;
			end
		end else if (ctl.clr) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_q[i] <= 8'd0;
			end
		end else if (ctl.wr) begin
			slot_q[wr_idx] <= wr_data;
		end
	end

	assign rd_data = slot_q[rd_idx];

	for (genvar j = 0; j < hkrt_pkg::SHOWN_SLOTS; j++) begin : g_shown
		if (j < SLOT_COUNT) begin : g_real
			assign shown[j] = slot_q[j];
		end else begin : g_none
			assign shown[j] = 8'd0;
		end
	end

endmodule

/* src/hid_key_report_tracker_core.sv */
// press or release: decode, scan every slot, then the result is registered
// type: a press result with last low, then a release result from a second decode and scan
// release all: clear, then the result; unmapped character: decode, then the result
// one item at a time: in_stall stays high until its last result is loaded; output stalls hold that load
// reset clears modifiers, all key slots and the result valid flag at once
module hid_key_report_tracker_core #(
	parameter int SLOT_COUNT = hkrt_pkg::SLOT_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] operation,
	input  logic [7:0] key_code,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] modifier_byte,
	output logic [7:0] slot_a,
	output logic [7:0] slot_b,
	output logic [7:0] slot_c,
	output logic [7:0] slot_d,
	output logic [7:0] slot_e,
	output logic [7:0] slot_f,
	output logic [1:0] status,
	output logic last
);

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CLEAR = 3'd1;
	localparam logic [2:0] S_DECODE = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [1:0] op_q;
	logic [7:0] code_q;
	logic phase_q;
	logic [7:0] usage_q;
	logic [7:0] mod_q;
	logic [IW-1:0] idx_q;
	logic present_q;
	logic free_found_q;
	logic [IW-1:0] free_idx_q;
	logic [1:0] stat_q;

	logic out_valid_q;
	logic [7:0] out_mod_q;
	logic [hkrt_pkg::SHOWN_SLOTS-1:0][7:0] out_slot_q;
	logic [1:0] out_stat_q;
	logic out_last_q;

	logic is_press;
	logic [7:0] rom;
	logic [7:0] mod_bit;
	logic [7:0] dec_mod;
	logic [7:0] dec_usage;
	logic dec_unmapped;

	logic [7:0] rd_data;
	logic [hkrt_pkg::SHOWN_SLOTS-1:0][7:0] shown;
	logic eq;
	logic zero;
	logic present_n;
	logic free_found_n;
	logic [IW-1:0] free_idx_n;
	logic last_idx;
	hkrt_pkg::slot_ctl_t ctl;
	logic [IW-1:0] wr_idx;
	logic [7:0] wr_data;
	logic load;
	logic type_first;

	assign is_press = (op_q == hkrt_pkg::OP_PRESS) || ((op_q == hkrt_pkg::OP_TYPE) && !phase_q);
	assign type_first = (op_q == hkrt_pkg::OP_TYPE) && !phase_q;
	assign rom = hkrt_pkg::USAGE_ROM[code_q[6:0]];
	assign mod_bit = 8'd1 << code_q[2:0];

	always_comb begin
		dec_mod = mod_q;
		dec_usage = 8'd0;
		dec_unmapped = 1'b0;
		if (code_q >= hkrt_pkg::RAW_BASE) begin
			dec_usage = code_q - hkrt_pkg::RAW_BASE;
		end else if (code_q[7]) begin
			dec_mod = is_press ? (mod_q | mod_bit) : (mod_q & ~mod_bit);
		end else if (rom == 8'd0) begin
			dec_unmapped = 1'b1;
		end else begin
			if ((rom & hkrt_pkg::SHIFT_FLAG) != 8'd0) begin
				dec_mod = is_press ? (mod_q | hkrt_pkg::LEFT_SHIFT_BIT)
					: (mod_q & ~hkrt_pkg::LEFT_SHIFT_BIT);
			end
			dec_usage = rom & ~hkrt_pkg::SHIFT_FLAG;
		end
	end

	// shared compare unit on the slot under the scan index
	assign eq = (rd_data == usage_q);
	assign zero = (rd_data == 8'd0);
	assign present_n = present_q | eq;
	assign free_found_n = free_found_q | zero;
	assign free_idx_n = free_found_q ? free_idx_q : idx_q;
	assign last_idx = (idx_q == IW'(SLOT_COUNT - 1));

	always_comb begin
		ctl.wr = 1'b0;
		ctl.clr = (state_q == S_CLEAR);
		wr_idx = idx_q;
		wr_data = 8'd0;
		if (state_q == S_SCAN) begin
			if (is_press) begin
				ctl.wr = last_idx && !present_n && free_found_n;
				wr_idx = free_idx_n;
				wr_data = usage_q;
			end else begin
				ctl.wr = (usage_q != 8'd0) && eq;
			end
		end
	end

	hkrt_slot_file #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_slots (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.wr_idx(wr_idx),
		.wr_data(wr_data),
		.rd_idx(idx_q),
		.rd_data(rd_data),
		.shown(shown)
	);

	assign load = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mod_q <= 8'd0;
			phase_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						phase_q <= 1'b0;
						state_q <= (operation == hkrt_pkg::OP_RELEASE_ALL) ? S_CLEAR : S_DECODE;
					end
				end
				S_CLEAR: begin
					mod_q <= 8'd0;
					state_q <= S_EMIT;
				end
				S_DECODE: begin
					mod_q <= dec_mod;
					state_q <= dec_unmapped ? S_EMIT : S_SCAN;
				end
				S_SCAN: begin
					if (last_idx) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load) begin
						if (type_first) begin
							phase_q <= 1'b1;
							state_q <= S_DECODE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q <= operation;
				code_q <= key_code;
			end
			S_CLEAR: begin
				stat_q <= hkrt_pkg::STAT_OK;
			end
			S_DECODE: begin
				usage_q <= dec_usage;
				idx_q <= '0;
				present_q <= 1'b0;
				free_found_q <= 1'b0;
				free_idx_q <= '0;
				stat_q <= dec_unmapped ? hkrt_pkg::STAT_UNMAPPED : hkrt_pkg::STAT_OK;
			end
			S_SCAN: begin
				present_q <= present_n;
				free_found_q <= free_found_n;
				free_idx_q <= free_idx_n;
				if (!last_idx) begin
					idx_q <= idx_q + IW'(1);
				end
				if (last_idx && is_press && !present_n && !free_found_n) begin
					stat_q <= hkrt_pkg::STAT_FULL;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_stat_q <= stat_q;
			out_last_q <= !type_first;
			if (stat_q == hkrt_pkg::STAT_OK) begin
				out_mod_q <= mod_q;
				out_slot_q <= shown;
			end else begin
				out_mod_q <= 8'd0;
				out_slot_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign modifier_byte = out_mod_q;
	assign slot_a = out_slot_q[0];
	assign slot_b = out_slot_q[1];
	assign slot_c = out_slot_q[2];
	assign slot_d = out_slot_q[3];
	assign slot_e = out_slot_q[4];
	assign slot_f = out_slot_q[5];
	assign status = out_stat_q;
	assign last = out_last_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q != S_IDLE)
		else $error("accepted item left the sequencer idle");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> idx_q <= IW'(SLOT_COUNT - 1))
		else $error("scan index beyond last slot");

	a_no_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != hkrt_pkg::STAT_OK |-> modifier_byte == 8'd0 && slot_a == 8'd0)
		else $error("report fields set on a result without report");

	a_full_only_press: assert property (@(posedge clk) disable iff (!arst_n)
		load && stat_q == hkrt_pkg::STAT_FULL |-> is_press)
		else $error("no free slot status outside a press");

endmodule

/* sim/hid_key_report_tracker_core_tb.sv */
module hid_key_report_tracker_core_tb;

	localparam int NSLOT = hkrt_pkg::SLOT_COUNT_DEF;
	localparam int RESULT_CYCLES = NSLOT + 3;
	localparam int TAIL_CYCLES = 2 * RESULT_CYCLES + 4;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int POOL_SIZE = 10;

	typedef struct packed {
		logic [7:0] modifier_byte;
		logic [5:0][7:0] slot;
		logic [1:0] status;
		logic last;
	} key_report_t;

	class key_report_scoreboard;
		logic [7:0] pressed_mods;
		logic [7:0] held_usages [NSLOT];
		key_report_t expected_reports [$];
		int errors;
		int items_noted;
		int reports_checked;
		int full_count;
		int unmapped_count;

		function new();
			pressed_mods = 8'h00;
			foreach (held_usages[i]) held_usages[i] = 8'h00;
			errors = 0;
			items_noted = 0;
			reports_checked = 0;
			full_count = 0;
			unmapped_count = 0;
		endfunction

		// applies the modifier or shift change, 0 means unmapped character
		function bit decode_key(input logic [7:0] code, input bit set, output logic [7:0] usage);
			logic [7:0] rom_entry;
			logic [7:0] mask;
			usage = 8'h00;
			if (code >= hkrt_pkg::RAW_BASE) begin
				usage = code - hkrt_pkg::RAW_BASE;
				return 1'b1;
			end
			if (code[7]) begin
				mask = 8'h01 << code[2:0];
				pressed_mods = set ? (pressed_mods | mask) : (pressed_mods & ~mask);
				return 1'b1;
			end
			rom_entry = hkrt_pkg::USAGE_ROM[code[6:0]];
			if (rom_entry == 8'h00)
				return 1'b0;
			if ((rom_entry & hkrt_pkg::SHIFT_FLAG) != 8'h00) begin
				pressed_mods = set ? (pressed_mods | hkrt_pkg::LEFT_SHIFT_BIT)
					: (pressed_mods & ~hkrt_pkg::LEFT_SHIFT_BIT);
				rom_entry = rom_entry & ~hkrt_pkg::SHIFT_FLAG;
			end
			usage = rom_entry;
			return 1'b1;
		endfunction

		function logic [1:0] apply_press(input logic [7:0] code);
			logic [7:0] usage;
			bit already;
			int free_idx;
			if (!decode_key(code, 1'b1, usage))
				return hkrt_pkg::STAT_UNMAPPED;
			already = 1'b0;
			foreach (held_usages[i])
				if (held_usages[i] == usage) already = 1'b1;
			if (already)
				return hkrt_pkg::STAT_OK;
			free_idx = -1;
			for (int i = 0; i < NSLOT; i++)
				if (held_usages[i] == 8'h00 && free_idx < 0) free_idx = i;
			if (free_idx < 0)
				return hkrt_pkg::STAT_FULL;
			held_usages[free_idx] = usage;
			return hkrt_pkg::STAT_OK;
		endfunction

		function logic [1:0] apply_release(input logic [7:0] code);
			logic [7:0] usage;
			if (!decode_key(code, 1'b0, usage))
				return hkrt_pkg::STAT_UNMAPPED;
			if (usage != 8'h00)
				foreach (held_usages[i])
					if (held_usages[i] == usage) held_usages[i] = 8'h00;
			return hkrt_pkg::STAT_OK;
		endfunction

		function void push_report(input logic [1:0] st, input logic fin);
			key_report_t r;
			r = '0;
			r.status = st;
			r.last = fin;
			if (st == hkrt_pkg::STAT_OK) begin
				r.modifier_byte = pressed_mods;
				for (int j = 0; j < hkrt_pkg::SHOWN_SLOTS; j++)
					r.slot[j] = (j < NSLOT) ? held_usages[j] : 8'h00;
			end
			if (st == hkrt_pkg::STAT_FULL) full_count++;
			if (st == hkrt_pkg::STAT_UNMAPPED) unmapped_count++;
			expected_reports.push_back(r);
		endfunction

		function void note_key_item(input logic [1:0] op, input logic [7:0] code);
			logic [1:0] st;
			items_noted++;
			case (op)
				hkrt_pkg::OP_PRESS: begin
					push_report(apply_press(code), 1'b1);
				end
				hkrt_pkg::OP_RELEASE: begin
					push_report(apply_release(code), 1'b1);
				end
				hkrt_pkg::OP_RELEASE_ALL: begin
					pressed_mods = 8'h00;
					foreach (held_usages[i]) held_usages[i] = 8'h00;
					push_report(hkrt_pkg::STAT_OK, 1'b1);
				end
				default: begin
					st = apply_press(code);
					push_report(st, 1'b0);
					st = apply_release(code);
					push_report(st, 1'b1);
				end
			endcase
		endfunction

		function void check_report(input key_report_t got);
			key_report_t want;
			string slot_names [6] = '{"slot_a", "slot_b", "slot_c", "slot_d", "slot_e", "slot_f"};
			if (expected_reports.size() == 0) begin
				$error("report with nothing expected: modifier_byte %h status %0d last %0d",
					got.modifier_byte, got.status, got.last);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			reports_checked++;
			if (got.modifier_byte !== want.modifier_byte) begin
				$error("modifier_byte expected %h actual %h", want.modifier_byte, got.modifier_byte);
				errors++;
			end
			for (int j = 0; j < hkrt_pkg::SHOWN_SLOTS; j++)
				if (got.slot[j] !== want.slot[j]) begin
					$error("%s expected %h actual %h", slot_names[j], want.slot[j], got.slot[j]);
					errors++;
				end
			if (got.status !== want.status) begin
				$error("status expected %0d actual %0d", want.status, got.status);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last expected %0d actual %0d", want.last, got.last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = hkrt_pkg::OP_PRESS;
	logic [7:0] key_code = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] modifier_byte;
	logic [7:0] slot_a;
	logic [7:0] slot_b;
	logic [7:0] slot_c;
	logic [7:0] slot_d;
	logic [7:0] slot_e;
	logic [7:0] slot_f;
	logic [1:0] status;
	logic last;

	key_report_scoreboard sb;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	logic [7:0] key_pool [POOL_SIZE];

	hid_key_report_tracker_core #(
		.SLOT_COUNT(NSLOT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.key_code(key_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.modifier_byte(modifier_byte),
		.slot_a(slot_a),
		.slot_b(slot_b),
		.slot_c(slot_c),
		.slot_d(slot_d),
		.slot_e(slot_e),
		.slot_f(slot_f),
		.status(status),
		.last(last)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		key_report_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_key_item(operation, key_code);
			if (out_valid && !out_stall) begin
				got.modifier_byte = modifier_byte;
				got.slot[0] = slot_a;
				got.slot[1] = slot_b;
				got.slot[2] = slot_c;
				got.slot[3] = slot_d;
				got.slot[4] = slot_e;
				got.slot[5] = slot_f;
				got.status = status;
				got.last = last;
				sb.check_report(got);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver: random stall, or a long hold when one is requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	task automatic send_key_item(input logic [1:0] op, input logic [7:0] code);
		int gaps;
		gaps = 0;
		while ($urandom_range(99) < tx_idle_pct) gaps++;
		if (gaps > 0) begin
			in_valid <= 1'b0;
			repeat (gaps) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		key_code <= code;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_reports_done();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] ascii_code(input bit mapped);
		logic [7:0] c;
		do c = 8'($urandom_range(127));
		while ((hkrt_pkg::USAGE_ROM[c[6:0]] != 8'h00) != mapped);
		return c;
	endfunction

	function automatic logic [7:0] pick_code();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) return key_pool[$urandom_range(POOL_SIZE - 1)];
		if (pick < 55) return 8'd128 + 8'($urandom_range(7));
		if (pick < 68) return hkrt_pkg::RAW_BASE + 8'($urandom_range(12));
		if (pick < 78) return ascii_code(1'b0);
		return 8'($urandom_range(255));
	endfunction

	task automatic random_items(input int count);
		int pick;
		logic [1:0] op;
		foreach (key_pool[i]) key_pool[i] = ascii_code(1'b1);
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 35) op = hkrt_pkg::OP_PRESS;
			else if (pick < 63) op = hkrt_pkg::OP_RELEASE;
			else if (pick < 92) op = hkrt_pkg::OP_TYPE;
			else op = hkrt_pkg::OP_RELEASE_ALL;
			send_key_item(op, pick_code());
		end
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 12;
		rx_idle_pct = 75;
		send_key_item(hkrt_pkg::OP_PRESS, 8'h61);
		send_key_item(hkrt_pkg::OP_PRESS, 8'h41);
		send_key_item(hkrt_pkg::OP_RELEASE, 8'h41);
		send_key_item(hkrt_pkg::OP_PRESS, 8'h80);
		send_key_item(hkrt_pkg::OP_PRESS, 8'h87);
		send_key_item(hkrt_pkg::OP_RELEASE, 8'h80);
		send_key_item(hkrt_pkg::OP_PRESS, hkrt_pkg::RAW_BASE);
		send_key_item(hkrt_pkg::OP_PRESS, 8'hFF);
		send_key_item(hkrt_pkg::OP_PRESS, 8'h00);
		send_key_item(hkrt_pkg::OP_RELEASE, 8'h7F);
		send_key_item(hkrt_pkg::OP_TYPE, 8'h01);
		send_key_item(hkrt_pkg::OP_PRESS, 8'h31);
		send_key_item(hkrt_pkg::OP_PRESS, 8'h32);
		send_key_item(hkrt_pkg::OP_PRESS, 8'h33);
		send_key_item(hkrt_pkg::OP_PRESS, 8'h0A);
		send_key_item(hkrt_pkg::OP_PRESS, 8'h20);
		// slot table now full
		send_key_item(hkrt_pkg::OP_PRESS, 8'h7E);
		send_key_item(hkrt_pkg::OP_PRESS, 8'h81);
		send_key_item(hkrt_pkg::OP_PRESS, hkrt_pkg::RAW_BASE);
		send_key_item(hkrt_pkg::OP_PRESS, 8'h31);
		send_key_item(hkrt_pkg::OP_RELEASE, hkrt_pkg::RAW_BASE);
		send_key_item(hkrt_pkg::OP_TYPE, 8'h62);
		send_key_item(hkrt_pkg::OP_TYPE, 8'h31);
		send_key_item(hkrt_pkg::OP_RELEASE_ALL, 8'hFF);
		send_key_item(hkrt_pkg::OP_TYPE, 8'h7A);
		wait_reports_done();

		random_items(200);
		hold_requests <= hold_requests + 1;
		random_items(300);
		wait_reports_done();

		tx_idle_pct = 75;
		rx_idle_pct = 12;
		random_items(500);
		wait_reports_done();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_items(500);
		wait_reports_done();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d key items and %0d reports under three idle profiles and a long hold,",
			sb.items_noted, sb.reports_checked);
		$display("with %0d full-table presses and %0d unmapped characters",
			sb.full_count, sb.unmapped_count);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* filelist.f */
src/hkrt_pkg.sv
src/hkrt_slot_file.sv
src/hid_key_report_tracker_core.sv
sim/hid_key_report_tracker_core_tb.sv
